// File: rtl/lru_key_value_cache_macros.svh
// ----------------------------------------------------------------------------
// LRU key-value cache assertion macros
// Clocked assertion helpers; define ASSERT_OFF to compile them out.
// ----------------------------------------------------------------------------
`ifndef LRU_KEY_VALUE_CACHE_MACROS_SVH
`define LRU_KEY_VALUE_CACHE_MACROS_SVH

`ifndef ASSERT_OFF
// prop must hold at every clock edge outside reset
`define LKV_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// cond must never be true at a clock edge outside reset
`define LKV_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    `LKV_ASSERT(label, clk, rst_n, !(cond), msg)
`else
`define LKV_ASSERT(label, clk, rst_n, prop, msg)
`define LKV_ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif

`endif

// File: rtl/lkv_pkg.sv
// ----------------------------------------------------------------------------
// LRU key-value cache package
// Field widths, operation codes and the lookup status shared by the modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lkv_pkg;

    localparam int CAP_W  = 5;
    localparam int KEY_W  = 32;
    localparam int DATA_W = 32;

    localparam logic [CAP_W-1:0]  CAP_RESET = 5'd16;
    localparam logic [DATA_W-1:0] MISS_DATA = '1;

    localparam logic KIND_GET = 1'b0;
    localparam logic KIND_PUT = 1'b1;

    typedef struct packed {
        logic hit;   // key present in a valid entry
        logic full;  // occupancy at or above the effective capacity
    } lkv_status_t;

endpackage

// File: rtl/lkv_lookup.sv
// ----------------------------------------------------------------------------
// LRU key-value cache lookup
// Parallel key compare, free slot pick, oldest entry pick and fill check.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lkv_lookup #(
    parameter int ENTRIES = 16,
    parameter int RANK_W  = 4,
    parameter int OCC_W   = 5
) (
    input  logic [ENTRIES-1:0]                   valid_vec,
    input  logic [ENTRIES-1:0][lkv_pkg::KEY_W-1:0] keys,
    input  logic [ENTRIES-1:0][RANK_W-1:0]       ranks,
    input  logic [OCC_W-1:0]                     occupancy,
    input  logic [lkv_pkg::CAP_W-1:0]            capacity,
    input  logic [lkv_pkg::KEY_W-1:0]            lookup_key,
    output logic [ENTRIES-1:0]                   match_vec,
    output logic [ENTRIES-1:0]                   free_vec,
    output logic [ENTRIES-1:0]                   oldest_vec,
    output lkv_pkg::lkv_status_t                 status
);

    import lkv_pkg::*;

    localparam int CMP_W = (CAP_W > OCC_W) ? CAP_W : OCC_W;

    logic [CMP_W-1:0] cap_ext;
    logic [CMP_W-1:0] cap_eff;
    logic [OCC_W-1:0] last_rank;

    always_comb
    begin
        cap_ext = CMP_W'(capacity);
        if (capacity == '0)
        begin
            cap_eff = CMP_W'(1);
        end
        else if (cap_ext > CMP_W'(ENTRIES))
        begin
            cap_eff = CMP_W'(ENTRIES);
        end
        else
        begin
            cap_eff = cap_ext;
        end
    end

    // ranks of valid entries run 0..occupancy-1, so the oldest holds the last one
    assign last_rank = occupancy - OCC_W'(1);

    always_comb
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            match_vec[i]  = valid_vec[i] && (keys[i] == lookup_key);
            oldest_vec[i] = valid_vec[i] && (OCC_W'(ranks[i]) == last_rank);
        end
    end

    // lowest clear bit of the valid vector
    assign free_vec = ~valid_vec & (valid_vec + ENTRIES'(1));

    assign status.hit  = |match_vec;
    assign status.full = CMP_W'(occupancy) >= cap_eff;

endmodule

// File: rtl/lkv_store.sv
// ----------------------------------------------------------------------------
// LRU key-value cache entry store
// Entry keys, values, valid marks, recency ranks and occupancy with update.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lkv_store #(
    parameter int ENTRIES = 16,
    parameter int RANK_W  = 4,
    parameter int OCC_W   = 5
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   op_valid,
    input  logic                                   op_kind,
    input  logic [lkv_pkg::KEY_W-1:0]              op_key,
    input  logic [lkv_pkg::DATA_W-1:0]             op_value,
    input  logic [ENTRIES-1:0]                     match_vec,
    input  logic [ENTRIES-1:0]                     free_vec,
    input  logic [ENTRIES-1:0]                     oldest_vec,
    input  lkv_pkg::lkv_status_t                   status,
    output logic [ENTRIES-1:0]                     valid_vec,
    output logic [ENTRIES-1:0][lkv_pkg::KEY_W-1:0] keys,
    output logic [ENTRIES-1:0][RANK_W-1:0]         ranks,
    output logic [OCC_W-1:0]                       occupancy,
    output logic [lkv_pkg::DATA_W-1:0]             read_data
);

    import lkv_pkg::*;

    logic [ENTRIES-1:0]              valid_reg;
    logic [ENTRIES-1:0]              valid_next;
    logic [ENTRIES-1:0][RANK_W-1:0]  rank_reg;
    logic [ENTRIES-1:0][RANK_W-1:0]  rank_next;
    logic [OCC_W-1:0]                occ_reg;
    logic [OCC_W-1:0]                occ_next;
    logic [ENTRIES-1:0][KEY_W-1:0]   key_reg;
    logic [ENTRIES-1:0][DATA_W-1:0]  data_reg;

    logic [ENTRIES-1:0] sel_vec;
    logic [ENTRIES-1:0] write_vec;
    logic [RANK_W-1:0]  touch_rank;
    logic               is_put;
    logic               touch_en;
    logic               insert_en;

    assign is_put    = (op_kind == KIND_PUT);
    assign touch_en  = op_valid && (status.hit || (is_put && status.full));
    assign insert_en = op_valid && is_put && !status.hit && !status.full;
    assign sel_vec   = status.hit ? match_vec : oldest_vec;

    always_comb
    begin
        if (!(op_valid && is_put))
        begin
            write_vec = '0;
        end
        else if (status.hit)
        begin
            write_vec = match_vec;
        end
        else if (status.full)
        begin
            write_vec = oldest_vec;
        end
        else
        begin
            write_vec = free_vec;
        end
    end

    // one-hot selects, so OR the picked lanes together
    always_comb
    begin
        read_data  = '0;
        touch_rank = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (match_vec[i])
            begin
                read_data = read_data | data_reg[i];
            end
            if (sel_vec[i])
            begin
                touch_rank = touch_rank | rank_reg[i];
            end
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        rank_next  = rank_reg;
        occ_next   = occ_reg;
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (touch_en)
            begin
                // make the touched entry newest and age every valid entry newer than it
                if (sel_vec[i])
                begin
                    rank_next[i] = '0;
                end
                else if (valid_reg[i] && (rank_reg[i] < touch_rank))
                begin
                    rank_next[i] = rank_reg[i] + RANK_W'(1);
                end
            end
            else if (insert_en)
            begin
                if (free_vec[i])
                begin
                    rank_next[i]  = '0;
                    valid_next[i] = 1'b1;
                end
                else if (valid_reg[i])
                begin
                    rank_next[i] = rank_reg[i] + RANK_W'(1);
                end
            end
        end
        if (insert_en)
        begin
            occ_next = occ_reg + OCC_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            rank_reg  <= '0;
            occ_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            rank_reg  <= rank_next;
            occ_reg   <= occ_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (write_vec[i])
            begin
                key_reg[i]  <= op_key;
                data_reg[i] <= op_value;
            end
        end
    end

    assign valid_vec = valid_reg;
    assign keys      = key_reg;
    assign ranks     = rank_reg;
    assign occupancy = occ_reg;

endmodule

// File: rtl/lru_key_value_cache.sv
// ----------------------------------------------------------------------------
// LRU key-value cache
// Fully associative key-value store with least-recently-used replacement.
//
//   channel   | ports                         | transfer
//   ----------+-------------------------------+------------------------------
//   command   | start, busy, kind, key, value | start high, busy low at edge
//   result    | done, hit, data               | done high for one cycle
//   config    | capacity_we, capacity         | capacity_we high at edge
//
// One command is taken every cycle. Its result passes from the command register
// to the result register and then shows on the result ports. The compare over
// all entries and the rank update run between the command register and the
// result register. busy stays low. Reset clears valid marks, ranks and
// occupancy at once; key and value storage is not cleared. Results cannot be
// stalled.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "lru_key_value_cache_macros.svh"

module lru_key_value_cache #(
    parameter int ENTRIES = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic                        kind,
    input  logic [lkv_pkg::KEY_W-1:0]   key,
    input  logic [lkv_pkg::DATA_W-1:0]  value,
    output logic                        done,
    output logic                        hit,
    output logic [lkv_pkg::DATA_W-1:0]  data,
    input  logic                        capacity_we,
    input  logic [lkv_pkg::CAP_W-1:0]   capacity
);

    import lkv_pkg::*;

    localparam int RANK_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int OCC_W  = $clog2(ENTRIES + 1);

    logic [CAP_W-1:0]  cap_reg;
    logic              in_valid_reg;
    logic              in_kind_reg;
    logic [KEY_W-1:0]  in_key_reg;
    logic [DATA_W-1:0] in_value_reg;
    logic              done_reg;
    logic              hit_reg;
    logic [DATA_W-1:0] data_reg;
    logic [DATA_W-1:0] data_next;

    logic [ENTRIES-1:0]             valid_vec;
    logic [ENTRIES-1:0][KEY_W-1:0]  keys;
    logic [ENTRIES-1:0][RANK_W-1:0] ranks;
    logic [OCC_W-1:0]               occupancy;
    logic [DATA_W-1:0]              read_data;
    logic [ENTRIES-1:0]             match_vec;
    logic [ENTRIES-1:0]             free_vec;
    logic [ENTRIES-1:0]             oldest_vec;
    lkv_status_t                    status;

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= CAP_RESET;
        end
        else if (capacity_we)
        begin
            cap_reg <= capacity;
        end
    end

    // command register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            in_kind_reg  <= kind;
            in_key_reg   <= key;
            in_value_reg <= value;
        end
    end

    lkv_lookup #(
        .ENTRIES (ENTRIES),
        .RANK_W  (RANK_W),
        .OCC_W   (OCC_W)
    ) u_lookup (
        .valid_vec  (valid_vec),
        .keys       (keys),
        .ranks      (ranks),
        .occupancy  (occupancy),
        .capacity   (cap_reg),
        .lookup_key (in_key_reg),
        .match_vec  (match_vec),
        .free_vec   (free_vec),
        .oldest_vec (oldest_vec),
        .status     (status)
    );

    lkv_store #(
        .ENTRIES (ENTRIES),
        .RANK_W  (RANK_W),
        .OCC_W   (OCC_W)
    ) u_store (
        .clk        (clk),
        .rst_n      (rst_n),
        .op_valid   (in_valid_reg),
        .op_kind    (in_kind_reg),
        .op_key     (in_key_reg),
        .op_value   (in_value_reg),
        .match_vec  (match_vec),
        .free_vec   (free_vec),
        .oldest_vec (oldest_vec),
        .status     (status),
        .valid_vec  (valid_vec),
        .keys       (keys),
        .ranks      (ranks),
        .occupancy  (occupancy),
        .read_data  (read_data)
    );

    always_comb
    begin
        if (in_kind_reg == KIND_PUT)
        begin
            data_next = in_value_reg;
        end
        else if (status.hit)
        begin
            data_next = read_data;
        end
        else
        begin
            data_next = MISS_DATA;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid_reg)
        begin
            hit_reg  <= status.hit;
            data_reg <= data_next;
        end
    end

    assign done = done_reg;
    assign hit  = hit_reg;
    assign data = data_reg;

    `LKV_ASSERT(a_result_follows, clk, rst_n, start |-> ##2 done, "command transfer without result")
    `LKV_ASSERT(a_unique_match, clk, rst_n, $onehot0(match_vec), "key held in two valid entries")
    `LKV_ASSERT(a_victim_exists, clk, rst_n, (in_valid_reg && status.full) |-> $onehot(oldest_vec), "full store without a single oldest entry")
    `LKV_ASSERT(a_free_exists, clk, rst_n, (in_valid_reg && !status.full) |-> $onehot(free_vec), "store below capacity without a free entry")

endmodule
